FILE: rtl/pngz_pkg.sv
// ----------------------------------------------------------------------------
// pngz_pkg
// Shared types, constants and helpers for the PNG stored zlib stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pngz_pkg;

    localparam int RUN_LEN = 18;
    localparam int POS_W   = 5;

    // byte positions inside the run of bytes caused by one colour byte
    localparam logic [POS_W-1:0] POS_ZHDR0 = 5'd0;
    localparam logic [POS_W-1:0] POS_ZHDR1 = 5'd1;
    localparam logic [POS_W-1:0] POS_BLKA  = 5'd2;
    localparam logic [POS_W-1:0] POS_FILT  = 5'd7;
    localparam logic [POS_W-1:0] POS_BLKB  = 5'd8;
    localparam logic [POS_W-1:0] POS_DATA  = 5'd13;
    localparam logic [POS_W-1:0] POS_ADLER = 5'd14;
    localparam logic [POS_W-1:0] POS_END   = 5'd17;

    localparam logic [7:0]  ZLIB_CMF   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG   = 8'h01;
    localparam logic [7:0]  FILTER_NONE = 8'h00;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [RUN_LEN-1:0] run_mask_t;

    typedef struct packed {
        run_mask_t   mask;
        logic        fin_a;
        logic [15:0] len_a;
        logic        fin_b;
        logic [15:0] len_b;
        logic [7:0]  data;
        logic [15:0] adl_hi;
        logic [15:0] adl_lo;
    } run_t;

    typedef struct packed {
        logic [29:0] total_len;
        logic [15:0] row_len;
    } geom_t;

    function automatic logic [15:0] adler_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= ADLER_MOD) begin
            s = s - ADLER_MOD;
        end
        return s[15:0];
    endfunction

    function automatic logic [POS_W-1:0] lowest_set(input run_mask_t m);
        logic [POS_W-1:0] p;
        p = '0;
        for (int i = RUN_LEN - 1; i >= 0; i--) begin
            if (m[i]) begin
                p = POS_W'(i);
            end
        end
        return p;
    endfunction

    function automatic run_mask_t above(input logic [POS_W-1:0] pos);
        run_mask_t a;
        for (int i = 0; i < RUN_LEN; i++) begin
            a[i] = (POS_W'(i) > pos);
        end
        return a;
    endfunction

    function automatic logic [7:0] run_byte(input run_t r, input logic [POS_W-1:0] pos);
        logic [7:0] b;
        case (pos)
            POS_ZHDR0:         b = ZLIB_CMF;
            POS_ZHDR1:         b = ZLIB_FLG;
            POS_BLKA:          b = {7'd0, r.fin_a};
            POS_BLKA + 5'd1:   b = r.len_a[7:0];
            POS_BLKA + 5'd2:   b = r.len_a[15:8];
            POS_BLKA + 5'd3:   b = ~r.len_a[7:0];
            POS_BLKA + 5'd4:   b = ~r.len_a[15:8];
            POS_FILT:          b = FILTER_NONE;
            POS_BLKB:          b = {7'd0, r.fin_b};
            POS_BLKB + 5'd1:   b = r.len_b[7:0];
            POS_BLKB + 5'd2:   b = r.len_b[15:8];
            POS_BLKB + 5'd3:   b = ~r.len_b[7:0];
            POS_BLKB + 5'd4:   b = ~r.len_b[15:8];
            POS_DATA:          b = r.data;
            POS_ADLER:         b = r.adl_hi[15:8];
            POS_ADLER + 5'd1:  b = r.adl_hi[7:0];
            POS_ADLER + 5'd2:  b = r.adl_lo[15:8];
            POS_ADLER + 5'd3:  b = r.adl_lo[7:0];
            default:           b = '0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pngz_cfg.sv
// ----------------------------------------------------------------------------
// pngz_cfg
// APB register file for image size; derives row length and raw stream length.
// ----------------------------------------------------------------------------
`default_nettype none

module pngz_cfg import pngz_pkg::*; #(
    parameter int unsigned MAX_DIM = 16384
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    input  wire logic        busy,
    output geom_t            geom
);

    localparam logic [14:0] DIM_MAX = 15'(MAX_DIM);

    logic [14:0] width_reg, width_next;
    logic [14:0] height_reg, height_next;
    geom_t       geom_reg, geom_next;
    logic        wr;
    logic [14:0] wdim;
    logic [15:0] row_len;
    logic [15:0] row_len_p1;

    function automatic logic [14:0] clamp_dim(input logic [14:0] x);
        logic [14:0] y;
        y = x;
        if (y == 15'd0) begin
            y = 15'd1;
        end
        if (y > DIM_MAX) begin
            y = DIM_MAX;
        end
        return y;
    endfunction

    assign wr   = psel && penable && pwrite && !busy;
    assign wdim = clamp_dim(pwdata[14:0]);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (wr && (paddr[2] == REG_IMAGE_WIDTH)) begin
            width_next = wdim;
        end
        if (wr && (paddr[2] == REG_IMAGE_HEIGHT)) begin
            height_next = wdim;
        end
        // three bytes per pixel, plus the filter byte per row
        row_len    = 16'({width_next, 1'b0}) + 16'(width_next);
        row_len_p1 = row_len + 16'd1;
        geom_next.row_len   = row_len;
        geom_next.total_len = 30'(height_next) * 30'(row_len_p1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg          <= 15'd1;
            height_reg         <= 15'd1;
            geom_reg.row_len   <= 16'd3;
            geom_reg.total_len <= 30'd4;
        end else if (wr) begin
            width_reg  <= width_next;
            height_reg <= height_next;
            geom_reg   <= geom_next;
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = {17'd0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {17'd0, height_reg};
            default:          prdata = '0;
        endcase
    end

    assign geom = geom_reg;

endmodule

`default_nettype wire

FILE: rtl/pngz_frame.sv
// ----------------------------------------------------------------------------
// pngz_frame
// Stream state: framing, block headers and running Adler-32 per colour byte.
// ----------------------------------------------------------------------------
`default_nettype none

module pngz_frame import pngz_pkg::*; #(
    parameter int unsigned BLOCK_MAX = 65535
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [7:0] color_byte,
    input  wire geom_t      geom,
    output logic            started,
    output run_t            run
);

    localparam logic [16:0] BM17 = 17'(BLOCK_MAX);
    localparam logic [29:0] BM30 = 30'(BLOCK_MAX);

    logic        started_reg;
    logic [15:0] fill_reg, fill_next;
    logic [15:0] rbi_reg, rbi_next;
    logic [29:0] rem_reg, rem_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;

    logic [29:0] rem0, rem1, rem2;
    logic [15:0] fill0, fill1, fill2;
    logic [15:0] rbi0, rbi_inc;
    logic [15:0] low0, low2;
    logic [15:0] high0, high1, high2;
    logic        filt, blk_a, blk_b, done;

    function automatic logic [15:0] fill_inc(input logic [15:0] f);
        logic [16:0] n;
        n = {1'b0, f} + 17'd1;
        if (n >= BM17) begin
            n = '0;
        end
        return n[15:0];
    endfunction

    function automatic logic [29:0] rem_dec(input logic [29:0] r);
        return (r != 30'd0) ? r - 30'd1 : r;
    endfunction

    function automatic logic [15:0] blk_len(input logic [29:0] r);
        return (r < BM30) ? r[15:0] : BM30[15:0];
    endfunction

    always_comb begin
        rem0  = started_reg ? rem_reg  : geom.total_len;
        fill0 = started_reg ? fill_reg : 16'd0;
        rbi0  = started_reg ? rbi_reg  : 16'd0;
        low0  = started_reg ? low_reg  : 16'd1;
        high0 = started_reg ? high_reg : 16'd0;

        // filter byte at the start of every row
        filt  = (rbi0 == 16'd0);
        blk_a = filt && (fill0 == 16'd0);
        fill1 = filt ? fill_inc(fill0) : fill0;
        rem1  = filt ? rem_dec(rem0) : rem0;
        high1 = filt ? adler_add(high0, low0) : high0;

        blk_b = (fill1 == 16'd0);
        low2  = adler_add(low0, {8'd0, color_byte});
        high2 = adler_add(high1, low2);
        fill2 = fill_inc(fill1);
        rem2  = rem_dec(rem1);
        done  = (rem2 == 30'd0);

        rbi_inc = rbi0 + 16'd1;

        run.mask   = {{4{done}}, 1'b1, {5{blk_b}}, filt, {5{blk_a}},
                      !started_reg, !started_reg};
        run.fin_a  = (rem0 <= BM30);
        run.len_a  = blk_len(rem0);
        run.fin_b  = (rem1 <= BM30);
        run.len_b  = blk_len(rem1);
        run.data   = color_byte;
        run.adl_hi = high2;
        run.adl_lo = low2;

        if (done) begin
            fill_next = '0;
            rbi_next  = '0;
            rem_next  = '0;
            low_next  = 16'd1;
            high_next = '0;
        end else begin
            fill_next = fill2;
            rbi_next  = (rbi_inc >= geom.row_len) ? 16'd0 : rbi_inc;
            rem_next  = rem2;
            low_next  = low2;
            high_next = high2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0;
            fill_reg    <= '0;
            rbi_reg     <= '0;
            rem_reg     <= '0;
            low_reg     <= 16'd1;
            high_reg    <= '0;
        end else if (accept) begin
            started_reg <= !done;
            fill_reg    <= fill_next;
            rbi_reg     <= rbi_next;
            rem_reg     <= rem_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
        end
    end

    assign started = started_reg;

endmodule

`default_nettype wire

FILE: rtl/pngz_ser.sv
// ----------------------------------------------------------------------------
// pngz_ser
// Result register: holds one run and sends its bytes one per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pngz_ser import pngz_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       load,
    input  wire run_t       run_in,
    output logic            free,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic      [7:0] m_out_byte,
    output logic            m_last_of_run,
    output logic            m_stream_end
);

    logic             valid_reg;
    run_t             run_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    run_mask_t        rest;
    logic             last;
    logic             take;

    assign rest = run_reg.mask & above(pos_reg);
    assign last = (rest == '0);
    assign take = valid_reg && m_ready;
    assign free = !valid_reg || (m_ready && last);

    always_comb begin
        pos_next = pos_reg;
        if (load) begin
            pos_next = lowest_set(run_in.mask);
        end else if (take && !last) begin
            pos_next = lowest_set(rest);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (take && last) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run_in;
        end
        pos_reg <= pos_next;
    end

    assign m_valid       = valid_reg;
    assign m_out_byte    = run_byte(run_reg, pos_reg);
    assign m_last_of_run = last;
    assign m_stream_end  = (pos_reg == POS_END);

endmodule

`default_nettype wire

FILE: rtl/png_stored_zlib_stream_encoder.sv
// ----------------------------------------------------------------------------
// png_stored_zlib_stream_encoder
// Turns RGB colour bytes into a zlib stream of stored deflate blocks.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one colour byte per transaction in raster order (R, G, B).
//   m_ channel gives the zlib stream one byte per transaction; m_last_of_run
//   marks the last byte caused by a colour byte, m_stream_end the last Adler
//   byte. Image size is set over APB (width at 0x0, height at 0x4) while idle.
//   The first byte of a run is on m_ in the cycle after its colour byte is
//   taken. A colour byte causes 1 to 18 output bytes (zlib header, filter
//   byte, block headers, Adler-32); the single result register sends one per
//   cycle while m_ready is high, and most pixel bytes cause only one byte.
//   A new colour byte is taken in the same cycle the last byte of the previous
//   run leaves. When m_ready is low the current byte holds and s_ready drops
//   until the run drains.
//   Reset clears the stream state and sets width and height to 1; the next
//   colour byte after a completed stream starts a new zlib stream.
// ----------------------------------------------------------------------------
`default_nettype none

module png_stored_zlib_stream_encoder import pngz_pkg::*; #(
    parameter int unsigned BLOCK_MAX = 65535,
    parameter int unsigned MAX_DIM   = 16384
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_color_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_out_byte,
    output logic             m_last_of_run,
    output logic             m_stream_end,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    geom_t geom;
    run_t  run;
    logic  started;
    logic  accept;

    assign pready = 1'b1;
    assign accept = s_valid && s_ready;

    pngz_cfg #(
        .MAX_DIM (MAX_DIM)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .busy    (started),
        .geom    (geom)
    );

    pngz_frame #(
        .BLOCK_MAX (BLOCK_MAX)
    ) u_frame (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .color_byte (s_color_byte),
        .geom       (geom),
        .started    (started),
        .run        (run)
    );

    pngz_ser u_ser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .run_in        (run),
        .free          (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_stream_end  (m_stream_end)
    );

`ifndef ASSERT_OFF
    // a run in progress keeps the output busy until its last byte
    a_run_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_of_run) |=> m_valid)
        else $error("run dropped before its last byte");

    a_end_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_stream_end) |-> m_last_of_run)
        else $error("stream end not at end of run");

    // no new colour byte while earlier bytes remain
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid || (m_ready && m_last_of_run)))
        else $error("input taken while a run is pending");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_png_stored_zlib_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_png_stored_zlib_stream_encoder
// Self-checking bench for the stored-block zlib encoder. A short table of
// directed rows (register extremes, read-back, writes during a stream, the
// first runs after reset) is followed by many small random images. Every
// output byte is compared with an in-bench zlib/Adler-32 model or with typed-in
// bytes, with bursty input and stalling output.
// ----------------------------------------------------------------------------

module tb_png_stored_zlib_stream_encoder import pngz_pkg::*; ();

    localparam int unsigned BLOCK_MAX     = 65535;
    localparam int unsigned MAX_DIM       = 16384;
    localparam int unsigned ADLER_BASE    = 65521;
    localparam int          RANDOM_ITEMS  = 150;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 5000000;

    localparam logic [2:0] ADDR_WIDTH  = {REG_IMAGE_WIDTH, 2'b00};
    localparam logic [2:0] ADDR_HEIGHT = {REG_IMAGE_HEIGHT, 2'b00};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fin;
    } zlib_byte_t;

    typedef enum logic [1:0] {ROW_PIXEL, ROW_WRITE, ROW_READ} row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic [2:0]   addr;
        logic [31:0]  value;
        int           typed_len;
        logic [143:0] typed_bytes;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_color_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_last_of_run;
    logic        m_stream_end;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    png_stored_zlib_stream_encoder uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_color_byte  (s_color_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_last_of_run (m_last_of_run),
        .m_stream_end  (m_stream_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // encoder model state
    int unsigned cfg_width = 1;
    int unsigned cfg_height = 1;
    bit          enc_started = 1'b0;
    int unsigned enc_block_fill = 0;
    int unsigned enc_row_pos = 0;
    int unsigned enc_raw_left = 0;
    int unsigned adler_a = 1;
    int unsigned adler_b = 0;

    zlib_byte_t predicted_run[$];
    zlib_byte_t expected_stream[$];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    logic [15:0] ready_pattern = 16'hFFFF;
    int          ready_hold = 0;

    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function automatic void emit_byte(input logic [7:0] b);
        zlib_byte_t z;
        z.data = b;
        z.last = 1'b0;
        z.fin  = 1'b0;
        predicted_run.push_back(z);
    endfunction

    function automatic void push_raw_byte(input logic [7:0] b);
        logic [31:0] blk_len;
        logic [15:0] nlen;
        if (enc_block_fill == 0) begin
            blk_len = (enc_raw_left < BLOCK_MAX) ? enc_raw_left : BLOCK_MAX;
            nlen    = ~blk_len[15:0];
            emit_byte((enc_raw_left <= BLOCK_MAX) ? 8'd1 : 8'd0);
            emit_byte(blk_len[7:0]);
            emit_byte(blk_len[15:8]);
            emit_byte(nlen[7:0]);
            emit_byte(nlen[15:8]);
        end
        emit_byte(b);
        adler_a += b;
        if (adler_a >= ADLER_BASE) adler_a -= ADLER_BASE;
        adler_b += adler_a;
        if (adler_b >= ADLER_BASE) adler_b -= ADLER_BASE;
        enc_block_fill++;
        if (enc_block_fill >= BLOCK_MAX) enc_block_fill = 0;
        if (enc_raw_left > 0) enc_raw_left--;
    endfunction

    // bytes of the zlib stream caused by one colour byte
    function automatic void encode_color_byte(input logic [7:0] c);
        zlib_byte_t z;
        predicted_run.delete();
        if (!enc_started) begin
            enc_started    = 1'b1;
            enc_raw_left   = cfg_height * (1 + 3 * cfg_width);
            enc_block_fill = 0;
            enc_row_pos    = 0;
            adler_a        = 1;
            adler_b        = 0;
            emit_byte(ZLIB_CMF);
            emit_byte(ZLIB_FLG);
        end
        if (enc_row_pos == 0) push_raw_byte(FILTER_NONE);
        push_raw_byte(c);
        enc_row_pos++;
        if (enc_row_pos >= 3 * cfg_width) enc_row_pos = 0;
        if (enc_raw_left == 0) begin
            emit_byte(8'(adler_b >> 8));
            emit_byte(8'(adler_b));
            emit_byte(8'(adler_a >> 8));
            emit_byte(8'(adler_a));
            z = predicted_run.pop_back();
            z.fin = 1'b1;
            predicted_run.push_back(z);
            enc_started    = 1'b0;
            enc_block_fill = 0;
            enc_row_pos    = 0;
            enc_raw_left   = 0;
            adler_a        = 1;
            adler_b        = 0;
        end
        z = predicted_run.pop_back();
        z.last = 1'b1;
        predicted_run.push_back(z);
    endfunction

    // writes during a stream leave the image size alone
    function automatic void set_dimension(input logic [2:0] addr, input logic [31:0] data);
        int unsigned x;
        if (enc_started) return;
        x = data[14:0];
        if (x < 1) x = 1;
        if (x > MAX_DIM) x = MAX_DIM;
        if (addr[2] == REG_IMAGE_WIDTH) cfg_width = x;
        else cfg_height = x;
    endfunction

    function automatic logic [31:0] dim_word(input int unsigned d);
        logic [31:0] r;
        r = $urandom;
        return {r[31:15], d[14:0]};
    endfunction

    function automatic stim_row_t make_row(input row_kind_t kind, input logic [2:0] addr,
                                           input logic [31:0] value, input int typed_len = 0,
                                           input logic [143:0] typed_bytes = '0);
        stim_row_t row;
        row.kind        = kind;
        row.addr        = addr;
        row.value       = value;
        row.typed_len   = typed_len;
        row.typed_bytes = typed_bytes;
        return row;
    endfunction

    // typed_len of zero takes the model's bytes, else the typed-in run
    task automatic send_color(input logic [7:0] c, input int typed_len,
                              input logic [143:0] typed_bytes);
        int         gap;
        zlib_byte_t z;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        encode_color_byte(c);
        if (typed_len == 0) begin
            foreach (predicted_run[i]) expected_stream.push_back(predicted_run[i]);
        end else begin
            for (int i = 0; i < typed_len; i++) begin
                z.data = typed_bytes[(typed_len - 1 - i) * 8 +: 8];
                z.last = (i == typed_len - 1);
                z.fin  = 1'b0;
                expected_stream.push_back(z);
            end
        end
        s_valid      <= 1'b1;
        s_color_byte <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_stream.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // data is the write value, or the expected value on a read
    task automatic apb_access(input logic is_write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= addr;
        pwdata  <= is_write ? data : $urandom;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (is_write) begin
            set_dimension(addr, data);
        end else if (prdata !== data) begin
            report_failure($sformatf("read addr %0h: expected %0h, got %0h", addr, data, prdata));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(input int unsigned w, input int unsigned h);
        wait_idle();
        apb_access(1'b1, ADDR_WIDTH, dim_word(w));
        apb_access(1'b1, ADDR_HEIGHT, dim_word(h));
    endtask

    // receiver stalls: m_ready follows a rotating random pattern
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_hold = 97;
            ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                        : (16'($urandom) | 16'h8888);
        end
        ready_hold--;
        ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
        m_ready <= ready_pattern[0];
    end

    always @(posedge aclk) begin
        zlib_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_stream.size() == 0) begin
                report_failure($sformatf("unexpected transaction: byte %0h last %0b end %0b",
                                         m_out_byte, m_last_of_run, m_stream_end));
            end else begin
                want = expected_stream.pop_front();
                if (m_out_byte !== want.data || m_last_of_run !== want.last ||
                    m_stream_end !== want.fin) begin
                    report_failure($sformatf(
                        "expected byte %0h last %0b end %0b, got byte %0h last %0b end %0b",
                        want.data, want.last, want.fin,
                        m_out_byte, m_last_of_run, m_stream_end));
                end
            end
        end
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        stim_row_t   directed_rows[$];
        stim_row_t   row;
        int          random_items;
        int unsigned stream_len;

        // 1x1 image after reset: zlib header, one final block of four raw bytes
        directed_rows.push_back(make_row(ROW_READ,  ADDR_WIDTH,  32'd1));
        directed_rows.push_back(make_row(ROW_READ,  ADDR_HEIGHT, 32'd1));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h55, 9,
                                         144'h78_01_01_04_00_FB_FF_00_55));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h00));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hFF));
        // next colour byte opens a fresh stream
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hAA, 9,
                                         144'h78_01_01_04_00_FB_FF_00_AA));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h01));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h80));
        // clamping of out-of-range sizes
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_WIDTH,  32'd0));
        directed_rows.push_back(make_row(ROW_READ,  ADDR_WIDTH,  32'd1));
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_WIDTH,  32'hFFFF_FFFF));
        directed_rows.push_back(make_row(ROW_READ,  ADDR_WIDTH,  32'd16384));
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_HEIGHT, 32'h0000_4001));
        directed_rows.push_back(make_row(ROW_READ,  ADDR_HEIGHT, 32'd16384));
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_HEIGHT, 32'hFFFF_8000));
        directed_rows.push_back(make_row(ROW_READ,  ADDR_HEIGHT, 32'd1));
        // 2x2 image, with an ignored write in the middle
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_WIDTH,  32'd2));
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_HEIGHT, 32'd2));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h00, 9,
                                         144'h78_01_01_0E_00_F1_FF_00_00));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hFF));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h7F));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h80));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hFE));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h01));
        directed_rows.push_back(make_row(ROW_WRITE, ADDR_WIDTH,  32'd5));
        directed_rows.push_back(make_row(ROW_READ,  ADDR_WIDTH,  32'd2));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h0F));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hF0));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h33));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hCC));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'h5A));
        directed_rows.push_back(make_row(ROW_PIXEL, 3'd0, 32'hA5));

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            case (row.kind)
                ROW_PIXEL: begin
                    send_color(row.value[7:0], row.typed_len, row.typed_bytes);
                end
                default: begin
                    wait_idle();
                    apb_access(row.kind == ROW_WRITE, row.addr, row.value);
                end
            endcase
        end

        // small random images, some back to back with the same size
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            if (random_items == 0 || $urandom_range(0, 3) != 0) begin
                configure($urandom_range(1, 6), $urandom_range(1, 5));
            end
            stream_len = 3 * cfg_width * cfg_height;
            for (int i = 0; i < stream_len; i++) begin
                if (i == stream_len / 2 && $urandom_range(0, 4) == 0) begin
                    wait_idle();
                    apb_access(1'b1, $urandom_range(0, 1) ? ADDR_WIDTH : ADDR_HEIGHT,
                               dim_word($urandom_range(0, MAX_DIM)));
                end
                send_color(8'($urandom_range(0, 255)), 0, '0);
            end
            random_items += stream_len;
        end

        wait_idle();
        if (mismatch_count == 0 && expected_stream.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/pngz_pkg.sv
rtl/pngz_cfg.sv
rtl/pngz_frame.sv
rtl/pngz_ser.sv
rtl/png_stored_zlib_stream_encoder.sv
tb/sv/tb_png_stored_zlib_stream_encoder.sv
